// ===== hdl/longest_prefix_match_router_assert.svh =====
// Assertion macros for the longest prefix match router
`ifndef LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH

// property holds at every clock edge out of reset
`define LPM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LPM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define LPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lpm_pkg.sv =====
// Types and constants shared by the longest prefix match router
`timescale 1ns / 1ps

package lpm_pkg;

	localparam int MAX_ROUTES = 32;
	localparam int IFACE_BITS = 4;
	localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
	localparam int LEN_W      = 6;
	localparam int ADDR_W     = 32;
	localparam int TTL_W      = 8;
	localparam int OUT_IFACE_W = 4;

	localparam logic [LEN_W-1:0] PREFIX_MAX = LEN_W'(ADDR_W);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ROUTES);

	typedef enum logic {
		FUNC_ADD   = 1'b0,
		FUNC_ROUTE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_ROUTE    = 2'd1,
		ST_TTL_EXPIRED = 2'd2,
		ST_TABLE_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [ADDR_W-1:0] dst_addr;
		logic [TTL_W-1:0]  ttl_in;
		logic [ADDR_W-1:0] add_prefix;
		logic [LEN_W-1:0]  prefix_len;
		logic              has_next_hop;
		logic [ADDR_W-1:0] next_hop_in;
		logic [3:0]        iface_in;
	} req_item_t;

	typedef struct packed {
		status_t                status;
		logic [OUT_IFACE_W-1:0] out_iface;
		logic [ADDR_W-1:0]      next_hop_out;
		logic [TTL_W-1:0]       ttl_out;
	} rsp_item_t;

	// item travelling down the row of route cells
	typedef struct packed {
		logic                  valid;
		func_t                 func;
		logic                  wr;
		logic [CNT_W-1:0]      rem;
		logic [ADDR_W-1:0]     dst;
		logic [TTL_W-1:0]      ttl;
		logic [ADDR_W-1:0]     prefix;
		logic [LEN_W-1:0]      len;
		logic                  has_hop;
		logic [ADDR_W-1:0]     hop;
		logic [IFACE_BITS-1:0] iface;
		logic                  found;
		logic [LEN_W-1:0]      best_len;
		logic                  best_has_hop;
		logic [ADDR_W-1:0]     best_hop;
		logic [IFACE_BITS-1:0] best_iface;
	} token_t;

endpackage

// ===== hdl/lpm_cell.sv =====
// One route cell: holds one table entry and forwards the passing item
`timescale 1ns / 1ps

module lpm_cell
	import lpm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  token_t prev_tok,
	output token_t next_tok
);

	logic [ADDR_W-1:0]     prefix_q;
	logic [ADDR_W-1:0]     mask_q;
	logic [LEN_W-1:0]      len_q;
	logic                  has_hop_q;
	logic [ADDR_W-1:0]     hop_q;
	logic [IFACE_BITS-1:0] iface_q;
	logic                  valid_q;
	token_t                tok_q;

	logic   occupied;
	logic   hit;
	logic   take;
	logic   slot;
	logic   store;
	token_t tok_d;

	assign occupied = (prev_tok.rem != '0);
	assign hit      = occupied && (((prefix_q ^ prev_tok.dst) & mask_q) == '0);
	assign take     = (prev_tok.func == FUNC_ROUTE) && hit
		&& (!prev_tok.found || (len_q > prev_tok.best_len));
	assign slot     = (prev_tok.func == FUNC_ADD) && prev_tok.wr && !occupied;
	assign store    = adv && prev_tok.valid && slot;

	always_comb begin
		tok_d = prev_tok;
		if (occupied) begin
			tok_d.rem = prev_tok.rem - 1'b1;
		end
		if (!occupied) begin
			tok_d.wr = 1'b0;
		end
		if (slot) begin
			tok_d.found = 1'b1;
		end
		if (take) begin
			tok_d.found        = 1'b1;
			tok_d.best_len     = len_q;
			tok_d.best_has_hop = has_hop_q;
			tok_d.best_hop     = hop_q;
			tok_d.best_iface   = iface_q;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			prefix_q  <= prev_tok.prefix;
			mask_q    <= ~({ADDR_W{1'b1}} >> prev_tok.len);
			len_q     <= prev_tok.len;
			has_hop_q <= prev_tok.has_hop;
			hop_q     <= prev_tok.has_hop ? prev_tok.hop : '0;
			iface_q   <= prev_tok.iface;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_tok.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_d;
		end
	end

	always_comb begin
		next_tok       = tok_q;
		next_tok.valid = valid_q;
	end

endmodule

// ===== hdl/longest_prefix_match_router.sv =====
// Top level of the longest prefix match router: row of route cells
//
// channel  dir  valid      stall      payload
// req      in   req_valid  req_stall  req (req_item_t)
// rsp      out  rsp_valid  rsp_stall  rsp (rsp_item_t)
//
// One item is taken per cycle while the row is not frozen; each result passes through
// the register of every route cell and then the output register before it appears on rsp.
// Reset clears the route count and the valid bits of the row; no clearing pass.
// A stall on rsp while a result waits freezes the whole row and raises req_stall.
`timescale 1ns / 1ps

module longest_prefix_match_router
	import lpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	`include "longest_prefix_match_router_assert.svh"

	logic             adv;
	logic             req_xfer;
	logic             add_xfer;
	logic             rsp_full;
	logic             full;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	rsp_item_t        rsp_d;
	token_t           head;
	token_t           chain [MAX_ROUTES+1];
	token_t           last;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;
	assign req_xfer  = req_valid && adv;
	assign full      = (count_q == FULL_COUNT);
	assign add_xfer  = req_xfer && (req.func == FUNC_ADD) && !full;

	always_comb begin
		head              = '0;
		head.valid        = req_xfer;
		head.func         = req.func;
		head.wr           = !full;
		head.rem          = count_q;
		head.dst          = req.dst_addr;
		head.ttl          = req.ttl_in;
		head.prefix       = req.add_prefix;
		head.len          = (req.prefix_len > PREFIX_MAX) ? PREFIX_MAX : req.prefix_len;
		head.has_hop      = req.has_next_hop;
		head.hop          = req.next_hop_in;
		head.iface        = IFACE_BITS'(req.iface_in);
	end

	assign chain[0] = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_xfer) begin
			count_q <= count_q + 1'b1;
		end
	end

	for (genvar g = 0; g < MAX_ROUTES; g++) begin : g_cell
		lpm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.prev_tok (chain[g]),
			.next_tok (chain[g+1])
		);
	end

	assign last = chain[MAX_ROUTES];

	always_comb begin
		rsp_d = '0;
		if (last.func == FUNC_ADD) begin
			rsp_d.status = last.found ? ST_OK : ST_TABLE_FULL;
		end else if (!last.found) begin
			rsp_d.status = ST_NO_ROUTE;
		end else if (last.ttl[TTL_W-1:1] == '0) begin
			rsp_d.status = ST_TTL_EXPIRED;
		end else begin
			rsp_d.status       = ST_OK;
			rsp_d.out_iface    = OUT_IFACE_W'(last.best_iface);
			rsp_d.next_hop_out = last.best_has_hop ? last.best_hop : last.dst;
			rsp_d.ttl_out      = last.ttl - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_full  = rsp_valid && (rsp.status == ST_TABLE_FULL);

	`LPM_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_COUNT, "route count above table size")
	`LPM_ASSERT_NEXT(a_add_counts, add_xfer, count_q == $past(count_q) + 1'b1, "route count stuck")
	`LPM_ASSERT_IMPLIES(a_full_status, rsp_full, full, "table full reported while not full")

endmodule

// ===== test/tb_longest_prefix_match_router.sv =====
// Self-checking testbench for the longest prefix match router: route adds and lookups
`timescale 1ns / 1ps

module tb_longest_prefix_match_router;
	import lpm_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = MAX_ROUTES + 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// route table as the block should hold it
	logic [ADDR_W-1:0]     tbl_prefix  [MAX_ROUTES];
	logic [LEN_W-1:0]      tbl_len     [MAX_ROUTES];
	logic                  tbl_has_hop [MAX_ROUTES];
	logic [ADDR_W-1:0]     tbl_hop     [MAX_ROUTES];
	logic [IFACE_BITS-1:0] tbl_iface   [MAX_ROUTES];
	int                    tbl_count = 0;

	// routes queued so far, used to aim lookups at stored prefixes
	logic [ADDR_W-1:0] plan_prefix [MAX_ROUTES];
	int                plan_len    [MAX_ROUTES];
	int                plan_count = 0;

	req_item_t pending_reqs[$];
	rsp_item_t expected_verdicts[$];
	rsp_item_t next_verdict;
	rsp_item_t want;

	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic [4:0] stall_tick = '0;
	int cycle_count = 0;
	int mismatches = 0;
	int items_sent = 0;
	int n_added = 0;
	int n_full = 0;
	int n_forwarded = 0;
	int n_unroutable = 0;
	int n_expired = 0;

	longest_prefix_match_router dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit prefix_hit(logic [ADDR_W-1:0] pfx, logic [LEN_W-1:0] len,
			logic [ADDR_W-1:0] addr);
		logic [ADDR_W-1:0] diff;
		diff = pfx ^ addr;
		if (len == '0)
			return 1'b1;
		return (diff >> (ADDR_W - len)) == '0;
	endfunction

	function automatic rsp_item_t forward_lookup(req_item_t it);
		rsp_item_t verdict;
		logic [LEN_W-1:0] len;
		int best;
		int idx;
		verdict = '0;
		verdict.status = ST_OK;
		best = -1;
		if (it.func == FUNC_ADD) begin
			if (tbl_count >= MAX_ROUTES) begin
				verdict.status = ST_TABLE_FULL;
			end else begin
				len = (it.prefix_len > PREFIX_MAX) ? PREFIX_MAX : it.prefix_len;
				tbl_prefix[tbl_count]  = it.add_prefix;
				tbl_len[tbl_count]     = len;
				tbl_has_hop[tbl_count] = it.has_next_hop;
				tbl_hop[tbl_count]     = it.has_next_hop ? it.next_hop_in : '0;
				tbl_iface[tbl_count]   = it.iface_in[IFACE_BITS-1:0];
				tbl_count++;
			end
			return verdict;
		end
		for (idx = 0; idx < tbl_count; idx++) begin
			if (prefix_hit(tbl_prefix[idx], tbl_len[idx], it.dst_addr) &&
					(best < 0 || tbl_len[idx] > tbl_len[best]))
				best = idx;
		end
		if (best < 0) begin
			verdict.status = ST_NO_ROUTE;
		end else if (it.ttl_in <= 8'd1) begin
			verdict.status = ST_TTL_EXPIRED;
		end else begin
			verdict.out_iface    = OUT_IFACE_W'(tbl_iface[best]);
			verdict.next_hop_out = tbl_has_hop[best] ? tbl_hop[best] : it.dst_addr;
			verdict.ttl_out      = it.ttl_in - 8'd1;
		end
		return verdict;
	endfunction

	function automatic req_item_t noise_item();
		req_item_t it;
		it.func         = func_t'($urandom_range(0, 1));
		it.dst_addr     = $urandom();
		it.ttl_in       = TTL_W'($urandom_range(0, 255));
		it.add_prefix   = $urandom();
		it.prefix_len   = LEN_W'($urandom_range(0, 63));
		it.has_next_hop = 1'($urandom_range(0, 1));
		it.next_hop_in  = $urandom();
		it.iface_in     = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic void queue_add(logic [ADDR_W-1:0] pfx, int len, bit has_hop,
			logic [ADDR_W-1:0] hop, logic [3:0] iface);
		req_item_t it;
		it = noise_item();
		it.func         = FUNC_ADD;
		it.add_prefix   = pfx;
		it.prefix_len   = LEN_W'(len);
		it.has_next_hop = has_hop;
		it.next_hop_in  = hop;
		it.iface_in     = iface;
		if (plan_count < MAX_ROUTES) begin
			plan_prefix[plan_count] = pfx;
			plan_len[plan_count]    = (len > ADDR_W) ? ADDR_W : len;
			plan_count++;
		end
		pending_reqs.push_back(it);
	endfunction

	function automatic void queue_datagram(logic [ADDR_W-1:0] dst, logic [TTL_W-1:0] ttl);
		req_item_t it;
		it = noise_item();
		it.func     = FUNC_ROUTE;
		it.dst_addr = dst;
		it.ttl_in   = ttl;
		pending_reqs.push_back(it);
	endfunction

	// address inside a queued route, sometimes just outside its last prefix bit
	function automatic logic [ADDR_W-1:0] aim_at(int idx);
		logic [ADDR_W-1:0] keep;
		logic [ADDR_W-1:0] addr;
		keep = (plan_len[idx] == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plan_len[idx]));
		addr = (plan_prefix[idx] & keep) | ($urandom() & ~keep);
		if (plan_len[idx] > 0 && $urandom_range(0, 3) == 0)
			addr ^= 32'h1 << (ADDR_W - plan_len[idx]);
		return addr;
	endfunction

	function automatic logic [TTL_W-1:0] random_ttl();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'hFF;
			default: return TTL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void random_datagram();
		if (plan_count > 0 && $urandom_range(0, 9) < 7)
			queue_datagram(aim_at($urandom_range(0, plan_count - 1)), random_ttl());
		else
			queue_datagram($urandom(), random_ttl());
	endfunction

	function automatic void random_add(bit allow_default);
		int pick;
		int idx;
		int len;
		logic [ADDR_W-1:0] pfx;
		pick = $urandom_range(0, 9);
		pfx = $urandom();
		len = $urandom_range(1, ADDR_W);
		if (plan_count > 0 && pick < 5) begin
			idx = $urandom_range(0, plan_count - 1);
			pfx = (pick == 0) ? plan_prefix[idx] : aim_at(idx);
			len = (pick == 0) ? plan_len[idx] : $urandom_range(plan_len[idx], ADDR_W);
		end else if (pick == 5) begin
			len = $urandom_range(ADDR_W + 1, 63);
		end else if (pick == 9 && allow_default) begin
			len = 0;
		end
		queue_add(pfx, len, 1'($urandom_range(0, 1)), $urandom(), 4'($urandom_range(0, 15)));
	endfunction

	task automatic drain_wait();
		while (pending_reqs.size() != 0 || req_valid || expected_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				next_verdict = forward_lookup(req);
				expected_verdicts.push_back(next_verdict);
				items_sent++;
				case (next_verdict.status)
					ST_OK: begin
						if (req.func == FUNC_ADD)
							n_added++;
						else
							n_forwarded++;
					end
					ST_NO_ROUTE:    n_unroutable++;
					ST_TTL_EXPIRED: n_expired++;
					ST_TABLE_FULL:  n_full++;
					default: ;
				endcase
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transfer, stall on a pattern that changes mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: result with none expected, status %0d",
							cycle_count, rsp.status);
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp.status !== want.status || rsp.out_iface !== want.out_iface ||
							rsp.next_hop_out !== want.next_hop_out ||
							rsp.ttl_out !== want.ttl_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"cycle %0d: expected status %0d iface %0h hop %08h ttl %0d,",
								" got status %0d iface %0h hop %08h ttl %0d"}, cycle_count,
								want.status, want.out_iface, want.next_hop_out, want.ttl_out,
								rsp.status, rsp.out_iface, rsp.next_hop_out, rsp.ttl_out);
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 200);
			end else begin
				mode_left--;
			end
			stall_tick <= stall_tick + 5'd1;
			case (stall_mode)
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= (stall_tick[1:0] == 2'b11);
				3: rsp_stall <= (stall_tick < 5'd18);
				default: rsp_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d results outstanding",
				expected_verdicts.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// lookups on an empty table, no route wins over an expired TTL
		queue_datagram(32'hC0A8_0101, 8'd0);
		queue_datagram(32'hFFFF_FFFF, 8'hFF);
		queue_add(32'h0A00_0000, 8, 1'b0, 32'h0000_0000, 4'hF);
		queue_add(32'h0A01_0000, 16, 1'b1, 32'hFFFF_FFFF, 4'h0);
		queue_add(32'h0A01_0203, 32, 1'b1, 32'h0A00_00FE, 4'h5);
		queue_add(32'h0A00_0000, 8, 1'b1, 32'h1234_5678, 4'h3);
		queue_add(32'hFFFF_FFFF, 63, 1'b1, 32'h0000_0000, 4'h9);
		queue_add(32'h8000_0000, 1, 1'b0, 32'hDEAD_BEEF, 4'h7);
		queue_add(32'hC0A8_0000, 33, 1'b0, 32'h5555_AAAA, 4'h2);
		queue_datagram(32'h0A01_0203, 8'd2);
		queue_datagram(32'h0A01_0204, 8'hFF);
		queue_datagram(32'h0A02_0000, 8'd64);
		queue_datagram(32'h0A01_0203, 8'd1);
		queue_datagram(32'h0A01_0203, 8'd0);
		queue_datagram(32'hFFFF_FFFF, 8'd128);
		queue_datagram(32'hFFFF_FFFE, 8'd10);
		queue_datagram(32'hC0A8_0000, 8'd3);
		queue_datagram(32'hC0A8_0001, 8'd3);
		queue_datagram(32'h0000_0001, 8'd3);

		// fill all but one slot while routing
		for (n = 0; n < RANDOM_ITEMS / 2; n++) begin
			if (plan_count < MAX_ROUTES - 1 && ($urandom_range(0, 99) < 6 ||
					RANDOM_ITEMS / 2 - n <= MAX_ROUTES - 1 - plan_count))
				random_add(1'b0);
			else
				random_datagram();
		end

		// hold the sender until every result is back, then add the default route
		drain_wait();
		queue_add($urandom(), 0, 1'($urandom_range(0, 1)), $urandom(),
			4'($urandom_range(0, 15)));

		for (n = 0; n < RANDOM_ITEMS / 2; n++) begin
			if ($urandom_range(0, 9) == 0)
				random_add(1'b1);
			else
				random_datagram();
		end

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_verdicts.size() != 0)
			mismatches++;

		$display("covered %0d items: %0d routes added, %0d adds refused on a full table",
			items_sent, n_added, n_full);
		$display("lookups: %0d forwarded, %0d without route, %0d with TTL expired",
			n_forwarded, n_unroutable, n_expired);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
